// ----- sv/mlsu_pkg.sv -----
// Package for the MIPS load/store unit: memory size, opcodes, status and
// target codes, stream widths and the stage-two control word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlsu_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 48;

    typedef logic [5:0] opcode_t;
    localparam opcode_t OP_LB  = 6'd32;
    localparam opcode_t OP_LH  = 6'd33;
    localparam opcode_t OP_LW  = 6'd35;
    localparam opcode_t OP_LBU = 6'd36;
    localparam opcode_t OP_LHU = 6'd37;
    localparam opcode_t OP_SB  = 6'd40;
    localparam opcode_t OP_SH  = 6'd41;
    localparam opcode_t OP_SW  = 6'd43;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_MISALIGN = 2'd1;
    localparam status_t ST_RANGE    = 2'd2;
    localparam status_t ST_IGNORED  = 2'd3;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_REG  = 2'd1;
    localparam kind_t KIND_MEM  = 2'd2;

    typedef struct packed {
        logic              preload;
        opcode_t           op;
        status_t           status;
        logic [4:0]        rt;
        logic [1:0]        lane;
        logic [MEM_AW-1:0] widx;
        logic [31:0]       pdata;
    } s2_ctl_t;

endpackage

`default_nettype wire

// ----- sv/mips_load_store_unit_top.sv -----
// MIPS load/store unit: lw/lh/lhu/lb/lbu/sw/sh/sb against a 32-entry register
// file and a word data memory, plus word preload.
// Depends on mlsu_pkg.
//
// Usage:
//   s_axis_* carries one word per command: tuser selects execute (0) or
//   preload (1); tdata holds the instruction, preload index and data.
//   m_axis_* returns exactly one result word per command, in order; tuser
//   carries the target kind, tdata the status, target index and value.
//   Pipeline: accept/register read, address and check/memory read,
//   extract or merge/write-back into the output register. One command is
//   accepted per cycle while no hazard, memory clear or back-pressure stalls.
//   A load whose result feeds the next command's base register stalls
//   stage one (the base register add waits for the write-back).
//   After aresetn the data memory is cleared one word per cycle, all MEM_WORDS
//   (4096) words, with s_axis_tready low; the register file clears at once.
//   When m_axis_tready is low the result is held in the output register,
//   stage two and stage one still take one command each, and then
//   s_axis_tready drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module mips_load_store_unit_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [31:0] instruction_word, [43:32] preload_index, [75:44] preload_data
    input  wire  [mlsu_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] action
    input  wire                          s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [1:0] status, [13:2] target_index, [45:14] result_value
    output logic [mlsu_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [1:0] target_kind
    output mlsu_pkg::kind_t              m_axis_tuser
);
    import mlsu_pkg::*;

    logic [31:0]       in_instr;
    logic [11:0]       in_pidx;
    logic [31:0]       in_pdata;
    logic              s_accept;

    logic              clr_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;

    logic [31:0]       rf_mem [32];
    logic [31:0]       rf_vld_reg;
    logic [31:0]       rf_rs_rd_reg, rf_rt_rd_reg;
    logic              rf_rs_ok_reg, rf_rt_ok_reg;
    logic              rf_fwd_vld_reg;
    logic [4:0]        rf_fwd_idx_reg;
    logic [31:0]       rf_fwd_data_reg;

    logic              s1_valid_reg, s1_fresh_reg, s1_preload_reg;
    logic [31:0]       s1_instr_reg;
    logic [11:0]       s1_pidx_reg;
    logic [31:0]       s1_pdata_reg;
    logic [31:0]       s1_rs_reg, s1_rs_next;
    logic [31:0]       s1_rt_reg, s1_rt_next;
    logic [4:0]        s1_rs_idx, s1_rt_idx;
    logic [31:0]       rs_cur, rt_cur;
    opcode_t           s1_op;
    logic [31:0]       s1_addr;
    logic [1:0]        s1_amask;
    logic              s1_op_ok;
    status_t           s1_status;
    logic [MEM_AW-1:0] s1_widx;
    s2_ctl_t           s1_ctl;
    logic              s1_hazard, s1_adv;

    logic              s2_valid_reg;
    s2_ctl_t           s2_ctl_reg;
    logic [31:0]       s2_rt_val_reg, s2_rt_val_next;
    logic              s2_adv;
    logic [31:0]       dm_mem [MEM_WORDS];
    logic [31:0]       dm_rd_reg;
    logic              dm_fwd_vld_reg;
    logic [MEM_AW-1:0] dm_fwd_idx_reg;
    logic [31:0]       dm_fwd_data_reg;
    logic [31:0]       s2_word, s2_shift, s2_load, s2_store;
    status_t           s2_status;
    kind_t             s2_kind;
    logic [11:0]       s2_tidx;
    logic [31:0]       s2_value;
    logic              s2_wr_reg, s2_wr_mem;

    logic              dm_we;
    logic [MEM_AW-1:0] dm_waddr;
    logic [31:0]       dm_wdata;

    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    kind_t             m_user_reg;

    assign in_instr = s_axis_tdata[31:0];
    assign in_pidx  = s_axis_tdata[43:32];
    assign in_pdata = s_axis_tdata[75:44];

    // ---------------- handshake ----------------
    assign s2_adv        = s2_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s1_adv        = s1_valid_reg && !s1_hazard && (!s2_valid_reg || s2_adv);
    assign s_axis_tready = !clr_reg && (!s1_valid_reg || s1_adv);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // ---------------- memory clear sweep ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_reg) begin
            clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            if (clr_cnt_reg == MEM_AW'(MEM_WORDS - 1)) begin
                clr_reg <= 1'b0;
            end
        end
    end

    // ---------------- register file ----------------
    always_ff @(posedge aclk) begin
        rf_rs_rd_reg <= rf_mem[in_instr[25:21]];
        rf_rt_rd_reg <= rf_mem[in_instr[20:16]];
        if (s2_adv && s2_wr_reg) begin
            rf_mem[s2_ctl_reg.rt] <= s2_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg     <= '0;
            rf_fwd_vld_reg <= 1'b0;
            rf_rs_ok_reg   <= 1'b0;
            rf_rt_ok_reg   <= 1'b0;
        end else begin
            rf_rs_ok_reg   <= rf_vld_reg[in_instr[25:21]];
            rf_rt_ok_reg   <= rf_vld_reg[in_instr[20:16]];
            rf_fwd_vld_reg <= s2_adv && s2_wr_reg;
            if (s2_adv && s2_wr_reg) begin
                rf_vld_reg[s2_ctl_reg.rt] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rf_fwd_idx_reg  <= s2_ctl_reg.rt;
        rf_fwd_data_reg <= s2_value;
    end

    // ---------------- stage one: address and checks ----------------
    assign s1_rs_idx = s1_instr_reg[25:21];
    assign s1_rt_idx = s1_instr_reg[20:16];
    assign s1_op     = s1_instr_reg[31:26];

    always_comb begin
        if (!s1_fresh_reg) begin
            rs_cur = s1_rs_reg;
        end else if (rf_fwd_vld_reg && rf_fwd_idx_reg == s1_rs_idx) begin
            rs_cur = rf_fwd_data_reg;
        end else begin
            rs_cur = rf_rs_ok_reg ? rf_rs_rd_reg : 32'd0;
        end
        if (!s1_fresh_reg) begin
            rt_cur = s1_rt_reg;
        end else if (rf_fwd_vld_reg && rf_fwd_idx_reg == s1_rt_idx) begin
            rt_cur = rf_fwd_data_reg;
        end else begin
            rt_cur = rf_rt_ok_reg ? rf_rt_rd_reg : 32'd0;
        end
    end

    always_comb begin
        s1_op_ok = 1'b1;
        case (s1_op)
            OP_LW, OP_SW:          s1_amask = 2'b11;
            OP_LH, OP_LHU, OP_SH:  s1_amask = 2'b01;
            OP_LB, OP_LBU, OP_SB:  s1_amask = 2'b00;
            default: begin
                s1_amask = 2'b00;
                s1_op_ok = 1'b0;
            end
        endcase
    end

    assign s1_addr = rs_cur + {{16{s1_instr_reg[15]}}, s1_instr_reg[15:0]};

    always_comb begin
        if (s1_preload_reg) begin
            s1_status = ({20'd0, s1_pidx_reg} < 32'(MEM_WORDS)) ? ST_OK : ST_RANGE;
            s1_widx   = MEM_AW'(s1_pidx_reg);
        end else begin
            s1_widx = s1_addr[MEM_AW+1:2];
            if (!s1_op_ok) begin
                s1_status = ST_IGNORED;
            end else if ((s1_addr[1:0] & s1_amask) != 2'b00) begin
                s1_status = ST_MISALIGN;
            end else if (s1_addr[31:2] >= 30'(MEM_WORDS)) begin
                s1_status = ST_RANGE;
            end else begin
                s1_status = ST_OK;
            end
        end
    end

    assign s1_ctl = '{preload: s1_preload_reg, op: s1_op, status: s1_status,
                      rt: s1_rt_idx, lane: s1_addr[1:0], widx: s1_widx,
                      pdata: s1_pdata_reg};

    assign s1_hazard = s1_valid_reg && s2_wr_reg && (s2_ctl_reg.rt == s1_rs_idx);

    always_comb begin
        s1_rs_next     = rs_cur;
        s1_rt_next     = rt_cur;
        s2_rt_val_next = rt_cur;
        if (s2_adv && s2_wr_reg) begin
            if (s2_ctl_reg.rt == s1_rs_idx) s1_rs_next = s2_value;
            if (s2_ctl_reg.rt == s1_rt_idx) begin
                s1_rt_next     = s2_value;
                s2_rt_val_next = s2_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_fresh_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                s1_fresh_reg <= 1'b1;
            end else begin
                s1_fresh_reg <= 1'b0;
                if (s1_adv) s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_rs_reg <= s1_rs_next;
        s1_rt_reg <= s1_rt_next;
        if (s_accept) begin
            s1_preload_reg <= s_axis_tuser;
            s1_instr_reg   <= in_instr;
            s1_pidx_reg    <= in_pidx;
            s1_pdata_reg   <= in_pdata;
        end
    end

    // ---------------- data memory ----------------
    assign s2_wr_mem = s2_valid_reg && (s2_kind == KIND_MEM);
    assign s2_wr_reg = s2_valid_reg && (s2_kind == KIND_REG);

    assign dm_we    = clr_reg || (s2_adv && s2_wr_mem);
    assign dm_waddr = clr_reg ? clr_cnt_reg : s2_ctl_reg.widx;
    assign dm_wdata = clr_reg ? 32'd0 : s2_value;

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        if (s1_adv) begin
            dm_rd_reg <= dm_mem[s1_widx];
        end
    end

    // write landing on the same edge as the read is not seen by the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dm_fwd_vld_reg <= 1'b0;
        end else if (s1_adv) begin
            dm_fwd_vld_reg <= s2_adv && s2_wr_mem;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            dm_fwd_idx_reg  <= s2_ctl_reg.widx;
            dm_fwd_data_reg <= s2_value;
        end
    end

    // ---------------- stage two: extract / merge ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_adv) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_ctl_reg    <= s1_ctl;
            s2_rt_val_reg <= s2_rt_val_next;
        end
    end

    assign s2_word  = (dm_fwd_vld_reg && dm_fwd_idx_reg == s2_ctl_reg.widx) ?
                      dm_fwd_data_reg : dm_rd_reg;
    assign s2_shift = s2_word >> {s2_ctl_reg.lane, 3'b000};

    always_comb begin
        case (s2_ctl_reg.op)
            OP_LH:   s2_load = {{16{s2_shift[15]}}, s2_shift[15:0]};
            OP_LHU:  s2_load = {16'd0, s2_shift[15:0]};
            OP_LB:   s2_load = {{24{s2_shift[7]}}, s2_shift[7:0]};
            OP_LBU:  s2_load = {24'd0, s2_shift[7:0]};
            default: s2_load = s2_word;
        endcase
        case (s2_ctl_reg.op)
            OP_SH: s2_store = (s2_word & ~(32'h0000_ffff << {s2_ctl_reg.lane, 3'b000}))
                            | ({16'd0, s2_rt_val_reg[15:0]} << {s2_ctl_reg.lane, 3'b000});
            OP_SB: s2_store = (s2_word & ~(32'h0000_00ff << {s2_ctl_reg.lane, 3'b000}))
                            | ({24'd0, s2_rt_val_reg[7:0]} << {s2_ctl_reg.lane, 3'b000});
            default: s2_store = s2_rt_val_reg;
        endcase
    end

    always_comb begin
        s2_status = s2_ctl_reg.status;
        s2_kind   = KIND_NONE;
        s2_tidx   = 12'd0;
        s2_value  = 32'd0;
        if (s2_ctl_reg.status == ST_OK) begin
            if (s2_ctl_reg.preload) begin
                s2_kind  = KIND_MEM;
                s2_tidx  = 12'(s2_ctl_reg.widx);
                s2_value = s2_ctl_reg.pdata;
            end else begin
                case (s2_ctl_reg.op)
                    OP_SW, OP_SH, OP_SB: begin
                        s2_kind  = KIND_MEM;
                        s2_tidx  = 12'(s2_ctl_reg.widx);
                        s2_value = s2_store;
                    end
                    default: begin
                        if (s2_ctl_reg.rt != 5'd0) begin
                            s2_kind  = KIND_REG;
                            s2_tidx  = {7'd0, s2_ctl_reg.rt};
                            s2_value = s2_load;
                        end
                    end
                endcase
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_data_reg <= {2'b00, s2_value, s2_tidx, s2_status};
            m_user_reg <= s2_kind;
        end
    end

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !s_axis_tready)
        else $error("word accepted during memory clear");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_NONE) |->
            (m_axis_tdata[45:2] == 44'd0))
        else $error("result with no target carries data");

    a_fail_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tuser == KIND_NONE))
        else $error("failed command reports a write");

    a_no_r0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_adv && s2_wr_reg) |-> (s2_ctl_reg.rt != 5'd0))
        else $error("write to register zero");

    a_hazard_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_hazard |=> s1_valid_reg)
        else $error("stage one lost a stalled command");

endmodule

`default_nettype wire

// ----- bench/tb_mips_load_store_unit_top.sv -----
// Testbench for mips_load_store_unit_top: directed table then random loads, stores and
// preloads, each result word checked against a behavioral model of registers and memory or a checked table row.
// Depends on mlsu_pkg and mips_load_store_unit_top.
`timescale 1ns / 1ps

module tb_mips_load_store_unit_top;
    import mlsu_pkg::*;

    localparam bit ACT_EXEC    = 1'b0;
    localparam bit ACT_PRELOAD = 1'b1;

    localparam int N_RANDOM     = 1000;
    localparam int HOT_WORDS    = 64;
    localparam int IDLE_PCT     = 36;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        status_t     status;
        kind_t       kind;
        logic [11:0] index;
        logic [31:0] value;
    } lsu_res_t;

    typedef struct packed {
        bit          act;
        logic [31:0] iw;
        logic [11:0] pidx;
        logic [31:0] pdata;
        bit          chk;
        lsu_res_t    want;
    } lsu_cmd_t;

    localparam lsu_res_t NO_RES = '0;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    kind_t               m_axis_tuser;

    logic [31:0] gold_regs [32]        = '{default: '0};
    logic [31:0] gold_mem  [MEM_WORDS] = '{default: '0};
    opcode_t     lsu_ops   [8]         = '{OP_LB, OP_LH, OP_LW, OP_LBU,
                                           OP_LHU, OP_SB, OP_SH, OP_SW};

    lsu_res_t pending_results [$];
    lsu_cmd_t directed_rows [$];
    int       fail_count = 0;
    int       stall_cycles = 0;
    bit       src_steady = 0;
    bit       sink_steady = 0;
    bit       sink_hold = 0;

    mips_load_store_unit_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] mk_iw(opcode_t op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // executes one word on the model state and returns the result it produces
    function automatic lsu_res_t lsu_execute(lsu_cmd_t c);
        lsu_res_t    r;
        opcode_t     op;
        logic [31:0] addr;
        logic [31:0] word;
        logic [31:0] shifted;
        logic [31:0] val;
        logic [1:0]  amask;
        logic [4:0]  lane;
        logic [4:0]  rt;
        int unsigned widx;
        r = '{ST_OK, KIND_NONE, 12'd0, 32'd0};
        if (c.act == ACT_PRELOAD) begin
            if (c.pidx >= MEM_WORDS) begin
                r.status = ST_RANGE;
                return r;
            end
            gold_mem[c.pidx] = c.pdata;
            r.kind  = KIND_MEM;
            r.index = c.pidx;
            r.value = c.pdata;
            return r;
        end
        op = c.iw[31:26];
        rt = c.iw[20:16];
        case (op)
            OP_LW, OP_SW:         amask = 2'b11;
            OP_LH, OP_LHU, OP_SH: amask = 2'b01;
            OP_LB, OP_LBU, OP_SB: amask = 2'b00;
            default: begin
                r.status = ST_IGNORED;
                return r;
            end
        endcase
        addr = gold_regs[c.iw[25:21]] + {{16{c.iw[15]}}, c.iw[15:0]};
        if ((addr[1:0] & amask) != 2'b00) begin
            r.status = ST_MISALIGN;
            return r;
        end
        if (addr[31:2] >= MEM_WORDS) begin
            r.status = ST_RANGE;
            return r;
        end
        widx    = addr[31:2];
        lane    = {addr[1:0], 3'b000};
        word    = gold_mem[widx];
        shifted = word >> lane;
        val     = gold_regs[rt];
        case (op)
            OP_LW:  val = word;
            OP_LH:  val = {{16{shifted[15]}}, shifted[15:0]};
            OP_LHU: val = {16'h0, shifted[15:0]};
            OP_LB:  val = {{24{shifted[7]}}, shifted[7:0]};
            OP_LBU: val = {24'h0, shifted[7:0]};
            OP_SW:  word = val;
            OP_SH:  word = (word & ~(32'h0000ffff << lane)) | ({16'h0, val[15:0]} << lane);
            default: word = (word & ~(32'h000000ff << lane)) | ({24'h0, val[7:0]} << lane);
        endcase
        if (op == OP_SW || op == OP_SH || op == OP_SB) begin
            gold_mem[widx] = word;
            r.kind  = KIND_MEM;
            r.index = widx[11:0];
            r.value = word;
        end else if (rt != 5'd0) begin
            gold_regs[rt] = val;
            r.kind  = KIND_REG;
            r.index = {7'd0, rt};
            r.value = val;
        end
        return r;
    endfunction

    function automatic lsu_cmd_t rand_cmd();
        lsu_cmd_t    c;
        opcode_t     op;
        logic [1:0]  off;
        logic [15:0] imm;
        int unsigned pick;
        c       = '0;
        c.act   = ACT_EXEC;
        c.iw    = $urandom;
        c.pidx  = 12'($urandom);
        c.pdata = $urandom;
        pick    = $urandom_range(0, 99);
        if (pick < 15) begin
            c.act = ACT_PRELOAD;
            if ($urandom_range(0, 3) != 0)
                c.pidx = 12'($urandom_range(0, HOT_WORDS - 1));
            case ($urandom_range(0, 2))
                0: c.pdata = $urandom_range(0, HOT_WORDS - 1) * 4;
                1: c.pdata = $urandom_range(0, MEM_WORDS - 1) * 4;
                default: ;
            endcase
        end else if (pick < 30) begin
            c.iw = mk_iw(OP_LW, 5'd0, 5'($urandom_range(1, 31)),
                         16'($urandom_range(0, HOT_WORDS - 1) * 4));
        end else if (pick < 95) begin
            op = lsu_ops[$urandom_range(0, 7)];
            case (op)
                OP_LW, OP_SW:         off = 2'd0;
                OP_LH, OP_LHU, OP_SH: off = {1'($urandom_range(0, 1)), 1'b0};
                default:              off = 2'($urandom_range(0, 3));
            endcase
            if ($urandom_range(0, 9) == 0)
                off = 2'($urandom_range(0, 3));
            imm = 16'($urandom_range(0, 31) * 4) - 16'd64 + {14'd0, off};
            if ($urandom_range(0, 19) == 0)
                imm = 16'($urandom);
            c.iw = mk_iw(op, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), imm);
        end
        return c;
    endfunction

    task automatic add_row(input bit act, input logic [31:0] iw, input logic [11:0] pidx,
                           input logic [31:0] pdata, input bit chk, input lsu_res_t want);
        directed_rows.push_back('{act, iw, pidx, pdata, chk, want});
    endtask

    task automatic send_word(input lsu_cmd_t c, output status_t st);
        lsu_res_t r;
        @(negedge aclk);
        while (!src_steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.act;
        s_axis_tdata  <= {4'b0, c.pdata, c.pidx, c.iw};
        forever begin
            @(posedge aclk);
            if (s_axis_tready)
                break;
        end
        r = lsu_execute(c);
        if (c.chk)
            r = c.want;
        pending_results.push_back(r);
        st = r.status;
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                sink_hold = 0;
            end else if (sink_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        lsu_res_t got;
        lsu_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.kind   = m_axis_tuser;
            got.index  = m_axis_tdata[13:2];
            got.value  = m_axis_tdata[45:14];
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: status %0d kind %0d index %0d value %h",
                       got.status, got.kind, got.index, got.value);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.kind !== want.kind) begin
                    $error("target_kind: expected %0d, got %0d", want.kind, got.kind);
                    fail_count++;
                end
                if (got.index !== want.index) begin
                    $error("target_index: expected %0d, got %0d", want.index, got.index);
                    fail_count++;
                end
                if (got.value !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, got.value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        status_t st;
        int      useful;
        int      item;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;

        // after reset, preload extremes, then every load and store on known words, then misalign/range/ignored cases
        add_row(ACT_EXEC, mk_iw(OP_LW, 5'd0, 5'd1, 16'h0000), 12'd0, 32'd0, 1'b1,
                '{ST_OK, KIND_REG, 12'd1, 32'd0});
        add_row(ACT_PRELOAD, 32'd0, 12'd4095, 32'hffffffff, 1'b1,
                '{ST_OK, KIND_MEM, 12'd4095, 32'hffffffff});
        add_row(ACT_PRELOAD, 32'd0, 12'd0, 32'h80ff7f01, 1'b1,
                '{ST_OK, KIND_MEM, 12'd0, 32'h80ff7f01});
        add_row(ACT_PRELOAD, 32'd0, 12'd1, 32'h00003ffc, 1'b1,
                '{ST_OK, KIND_MEM, 12'd1, 32'h00003ffc});
        add_row(ACT_EXEC, mk_iw(OP_LW, 5'd0, 5'd2, 16'h0004), 12'd0, 32'd0, 1'b1,
                '{ST_OK, KIND_REG, 12'd2, 32'h3ffc});
        add_row(ACT_EXEC, mk_iw(OP_LW, 5'd2, 5'd3, 16'h0000), 12'd0, 32'd0, 1'b1,
                '{ST_OK, KIND_REG, 12'd3, 32'hffffffff});
        add_row(ACT_EXEC, mk_iw(OP_LB, 5'd0, 5'd4, 16'h0000), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_LB, 5'd0, 5'd5, 16'h0003), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_LBU, 5'd0, 5'd6, 16'h0003), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_LH, 5'd0, 5'd7, 16'h0002), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_LHU, 5'd0, 5'd8, 16'h0002), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_LH, 5'd0, 5'd9, 16'h0000), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_SB, 5'd0, 5'd3, 16'h0001), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_SH, 5'd0, 5'd5, 16'h0002), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_SW, 5'd0, 5'd3, 16'h0008), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_SW, 5'd0, 5'd0, 16'h3ffc), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, mk_iw(OP_LW, 5'd0, 5'd0, 16'h0000), 12'd0, 32'd0, 1'b1,
                '{ST_OK, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_LW, 5'd0, 5'd1, 16'h0002), 12'd0, 32'd0, 1'b1,
                '{ST_MISALIGN, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_LH, 5'd0, 5'd1, 16'h0001), 12'd0, 32'd0, 1'b1,
                '{ST_MISALIGN, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_SH, 5'd0, 5'd1, 16'h0003), 12'd0, 32'd0, 1'b1,
                '{ST_MISALIGN, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_LW, 5'd0, 5'd1, 16'h4002), 12'd0, 32'd0, 1'b1,
                '{ST_MISALIGN, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_SW, 5'd0, 5'd1, 16'h4000), 12'd0, 32'd0, 1'b1,
                '{ST_RANGE, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_LB, 5'd0, 5'd1, 16'hffff), 12'd0, 32'd0, 1'b1,
                '{ST_RANGE, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_LBU, 5'd0, 5'd31, 16'h7fff), 12'd0, 32'd0, 1'b1,
                '{ST_RANGE, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, mk_iw(OP_LW, 5'd2, 5'd1, 16'h7ffc), 12'd0, 32'd0, 1'b0, NO_RES);
        add_row(ACT_EXEC, 32'h00000000, 12'd0, 32'd0, 1'b1,
                '{ST_IGNORED, KIND_NONE, 12'd0, 32'd0});
        add_row(ACT_EXEC, 32'hffffffff, 12'd0, 32'd0, 1'b1,
                '{ST_IGNORED, KIND_NONE, 12'd0, 32'd0});

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i], st);

        useful = 0;
        item   = 0;
        while (useful < N_RANDOM) begin
            src_steady  = (item >= 100 && item < 250);
            sink_steady = src_steady;
            if (item == 400)
                sink_hold = 1;
            if (item == 700) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge aclk);
            end
            send_word(rand_cmd(), st);
            if (st != ST_IGNORED)
                useful++;
            item++;
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- mips_load_store_unit_top.f -----
sv/mlsu_pkg.sv
sv/mips_load_store_unit_top.sv
bench/tb_mips_load_store_unit_top.sv
